/* rtl/mdu_pkg.sv */
// Shared types and register offsets for the multiply/divide register unit.
package mdu_pkg;

    // Access kinds carried by the op field.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register offsets relative to the block base.
    localparam logic [4:0] OFF_MPYA = 5'h02;
    localparam logic [4:0] OFF_MPYB = 5'h03;
    localparam logic [4:0] OFF_DIVL = 5'h04;
    localparam logic [4:0] OFF_DIVH = 5'h05;
    localparam logic [4:0] OFF_DIVB = 5'h06;
    localparam logic [4:0] OFF_QL   = 5'h14;
    localparam logic [4:0] OFF_QH   = 5'h15;
    localparam logic [4:0] OFF_PRL  = 5'h16;
    localparam logic [4:0] OFF_PRH  = 5'h17;

    // Iteration counts of the shared shift units.
    localparam int MUL_STEPS  = 8;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Quotient forced on a zero divisor.
    localparam logic [15:0] DIV_ZERO_QUOT = 16'hffff;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul_step;
        logic div_step;
    } cmd_t;

    // Decoded status of the presented item, from the datapath.
    typedef struct packed {
        logic mul_start;
        logic div_start;
    } status_t;

endpackage

/* rtl/mdu_ctrl.sv */
// Controller state machine: handshakes, step counter and output valid.
module mdu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mdu_pkg::status_t status,
    output mdu_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

    state_t                             state_reg, state_next;
    logic [mdu_pkg::STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               accept;

    // An item enters only when idle and the output slot is free or draining.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.accept   = accept;
    assign cmd.mul_step = (state_reg == S_MUL);
    assign cmd.div_step = (state_reg == S_DIV);

    // Next state, step count and output valid.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && status.mul_start)
                begin
                    state_next = S_MUL;
                    cnt_next   = mdu_pkg::STEP_CNT_W'(mdu_pkg::MUL_STEPS - 1);
                end
                else if (accept && status.div_start)
                begin
                    state_next = S_DIV;
                    cnt_next   = mdu_pkg::STEP_CNT_W'(mdu_pkg::DIV_STEPS - 1);
                end
            end
            S_MUL, S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The counter is parked at zero whenever the controller is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg == '0))
        else $error("step counter not zero while idle");

    // A multiply start moves straight into the multiply iterations.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.mul_start) |=> (state_reg == S_MUL))
        else $error("multiply start did not enter multiply state");

    // A waiting result is never dropped before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result lost");

    // A divide never starts while a multiply is being decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(status.mul_start && status.div_start))
        else $error("conflicting start decode");

endmodule

/* rtl/mdu_datapath.sv */
// Datapath: operand and result registers, shift-add multiply, restoring divide.
module mdu_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op,
    input  logic [4:0]       reg_offset,
    input  logic [7:0]       data_in,
    input  mdu_pkg::cmd_t    cmd,
    output mdu_pkg::status_t status,
    output logic [7:0]       read_data
);

    logic [7:0]  mcand_reg, mcand_next;
    logic [15:0] dividend_reg, dividend_next;
    logic [7:0]  divisor_reg, divisor_next;
    logic [15:0] quot_reg, quot_next;
    logic [15:0] prodrem_reg, prodrem_next;
    logic [7:0]  read_data_reg, read_data_next;

    logic        is_write;
    logic [8:0]  mul_sum;
    logic [8:0]  div_trial;
    logic [8:0]  div_diff;
    logic        div_ge;

    // Start decode of the presented item.
    assign is_write         = (op == mdu_pkg::OP_WRITE);
    assign status.mul_start = is_write && (reg_offset == mdu_pkg::OFF_MPYB);
    assign status.div_start = is_write && (reg_offset == mdu_pkg::OFF_DIVB)
                              && (data_in != 8'h00);

    // One shift-add step: the high byte accumulates, the multiplier shifts out below.
    // The multiplier byte itself stays visible in the high byte of the quotient register.
    assign mul_sum = {1'b0, prodrem_reg[15:8]}
                     + {1'b0, (prodrem_reg[0] ? mcand_reg : 8'h00)};

    // One restoring divide step: the remainder takes the next dividend bit.
    assign div_trial = {prodrem_reg[7:0], quot_reg[15]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});

    // Register writes, read mux and iteration steps.
    always_comb
    begin
        mcand_next     = mcand_reg;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        quot_next      = quot_reg;
        prodrem_next   = prodrem_reg;
        read_data_next = read_data_reg;
        if (cmd.accept)
        begin
            if (is_write)
            begin
                read_data_next = 8'h00;
                unique case (reg_offset)
                    mdu_pkg::OFF_MPYA:
                    begin
                        mcand_next = data_in;
                    end
                    mdu_pkg::OFF_MPYB:
                    begin
                        quot_next    = {data_in, mcand_reg};
                        prodrem_next = {8'h00, data_in};
                    end
                    mdu_pkg::OFF_DIVL:
                    begin
                        dividend_next = {dividend_reg[15:8], data_in};
                    end
                    mdu_pkg::OFF_DIVH:
                    begin
                        dividend_next = {data_in, dividend_reg[7:0]};
                    end
                    mdu_pkg::OFF_DIVB:
                    begin
                        divisor_next = data_in;
                        if (data_in == 8'h00)
                        begin
                            quot_next    = mdu_pkg::DIV_ZERO_QUOT;
                            prodrem_next = dividend_reg;
                        end
                        else
                        begin
                            quot_next    = dividend_reg;
                            prodrem_next = 16'h0000;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                unique case (reg_offset)
                    mdu_pkg::OFF_QL:  read_data_next = quot_reg[7:0];
                    mdu_pkg::OFF_QH:  read_data_next = quot_reg[15:8];
                    mdu_pkg::OFF_PRL: read_data_next = prodrem_reg[7:0];
                    mdu_pkg::OFF_PRH: read_data_next = prodrem_reg[15:8];
                    default:          read_data_next = data_in;
                endcase
            end
        end
        else if (cmd.mul_step)
        begin
            prodrem_next = {mul_sum, prodrem_reg[7:1]};
        end
        else if (cmd.div_step)
        begin
            prodrem_next = {8'h00, (div_ge ? div_diff[7:0] : div_trial[7:0])};
            quot_next    = {quot_reg[14:0], div_ge};
        end
    end

    // All registers reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcand_reg     <= '0;
            dividend_reg  <= '0;
            divisor_reg   <= '0;
            quot_reg      <= '0;
            prodrem_reg   <= '0;
            read_data_reg <= '0;
        end
        else
        begin
            mcand_reg     <= mcand_next;
            dividend_reg  <= dividend_next;
            divisor_reg   <= divisor_next;
            quot_reg      <= quot_next;
            prodrem_reg   <= prodrem_next;
            read_data_reg <= read_data_next;
        end
    end

    assign read_data = read_data_reg;

endmodule

/* rtl/mul8_div16_register_unit.sv */
// Top level of the memory-mapped 8x8 multiply and 16-by-8 divide unit.
// Each item is one register access and returns one byte (zero for writes).
// Reads, plain writes and a divide by zero are done without iterating. Writing the
// multiplier runs an 8-step shift-add multiply and writing a nonzero divisor
// runs a 16-step restoring divide in one shared result datapath; input ready
// stays low while those steps run. The result byte sits in an output register,
// and a new item is taken only when that register is empty or its result
// leaves in the same cycle, so a stalled output holds the input off for as
// long as the stall lasts.
module mul8_div16_register_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [4:0] reg_offset,
    input  logic [7:0] data_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    mdu_pkg::cmd_t    cmd;
    mdu_pkg::status_t status;

    // Sequencing and handshakes.
    mdu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Registers and arithmetic.
    mdu_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .reg_offset (reg_offset),
        .data_in    (data_in),
        .cmd        (cmd),
        .status     (status),
        .read_data  (read_data)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the multiply/divide register unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // One register access waiting to be driven, with its pacing.
    typedef struct packed {
        logic        op;
        logic [4:0]  off;
        logic [7:0]  data;
        int unsigned gap;
        bit          drain;
        int unsigned rx_pct;
    } access_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       op = mdu_pkg::OP_WRITE;
    logic [4:0] reg_offset = 5'd0;
    logic [7:0] data_in = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;

    access_t     access_queue[$];
    access_t     next_access;
    logic [7:0]  expected_bytes[$];
    logic        in_taken = 1'b0;
    int unsigned rx_pct = 0;
    int unsigned stall_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_index = 0;

    // Shadow copy of the unit's registers.
    logic [7:0]  mcand;
    logic [7:0]  mplier;
    logic [15:0] dvd;
    logic [7:0]  dvs;
    logic [15:0] quot;
    logic [15:0] prem;

    // Knobs used while the access list is built.
    int unsigned cur_gap_pct;
    int unsigned cur_rx_pct;
    bit          next_drain;
    int unsigned live_count;

    mul8_div16_register_unit uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .reg_offset (reg_offset),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    // Free-running 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one access to the shadow registers and returns the byte it yields.
    function automatic logic [7:0] mdu_access(input logic acc_op, input logic [4:0] off,
                                              input logic [7:0] d);
        logic [7:0] rd;
        rd = 8'd0;
        if (acc_op == mdu_pkg::OP_WRITE)
        begin
            case (off)
                mdu_pkg::OFF_MPYA: mcand = d;
                mdu_pkg::OFF_MPYB:
                begin
                    mplier = d;
                    quot = {mplier, mcand};
                    prem = 16'(mcand) * 16'(mplier);
                end
                mdu_pkg::OFF_DIVL: dvd[7:0] = d;
                mdu_pkg::OFF_DIVH: dvd[15:8] = d;
                mdu_pkg::OFF_DIVB:
                begin
                    dvs = d;
                    if (dvs == 8'd0)
                    begin
                        quot = mdu_pkg::DIV_ZERO_QUOT;
                        prem = dvd;
                    end
                    else
                    begin
                        quot = dvd / 16'(dvs);
                        prem = dvd % 16'(dvs);
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            case (off)
                mdu_pkg::OFF_QL:  rd = quot[7:0];
                mdu_pkg::OFF_QH:  rd = quot[15:8];
                mdu_pkg::OFF_PRL: rd = prem[7:0];
                mdu_pkg::OFF_PRH: rd = prem[15:8];
                default:          rd = d;
            endcase
        end
        return rd;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Data bytes lean toward the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h01;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_access(input logic acc_op, input logic [4:0] off, input logic [7:0] d);
        access_t a;
        a.op = acc_op;
        a.off = off;
        a.data = d;
        a.gap = pick_gap(cur_gap_pct);
        a.drain = next_drain;
        a.rx_pct = cur_rx_pct;
        next_drain = 1'b0;
        access_queue.push_back(a);
        // Writes to unmapped offsets do nothing and are not counted.
        if (acc_op == mdu_pkg::OP_READ
            || (off >= mdu_pkg::OFF_MPYA && off <= mdu_pkg::OFF_DIVB))
            live_count++;
    endtask

    task automatic add_result_reads();
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n)
            add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QL + 5'($urandom_range(0, 3)),
                       8'($urandom));
    endtask

    // Driver: presents queued items at the falling edge and holds each until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (access_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (access_queue[0].gap != 0)
            begin
                in_valid <= 1'b0;
                access_queue[0].gap = access_queue[0].gap - 1;
            end
            else if (access_queue[0].drain && expected_bytes.size() != 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_access = access_queue.pop_front();
                in_valid <= 1'b1;
                op <= next_access.op;
                reg_offset <= next_access.off;
                data_in <= next_access.data;
                rx_pct <= next_access.rx_pct;
            end
        end
    end

    // Result side: random stalls of out_ready.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 99) < rx_pct)
        begin
            out_ready <= 1'b0;
            stall_left = pick_gap(100) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: checks results first, then predicts for any item taken at this edge.
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result read_data=%02h", read_data));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (read_data !== want)
                        report_mismatch($sformatf("result %0d: read_data=%02h, wanted %02h",
                                                  result_index, read_data, want));
                end
                result_index++;
            end
            if (in_valid && in_ready)
                expected_bytes.push_back(mdu_access(op, reg_offset, data_in));
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        mcand = 8'd0;
        mplier = 8'd0;
        dvd = 16'd0;
        dvs = 8'd0;
        quot = 16'd0;
        prem = 16'd0;
        cur_gap_pct = 30;
        cur_rx_pct = 30;
        next_drain = 1'b0;
        live_count = 0;

        // Directed part: reset values, extreme operands, divide by zero, unmapped offsets.
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QH, 8'hff);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRH, 8'hff);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_MPYA, 8'hff);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_MPYB, 8'hff);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QH, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRH, 8'h00);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVL, 8'h34);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVH, 8'h12);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVB, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QH, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRL, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRH, 8'h00);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVB, 8'hff);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_QH, 8'h00);
        add_access(mdu_pkg::OP_READ, mdu_pkg::OFF_PRL, 8'h00);
        add_access(mdu_pkg::OP_READ, 5'h1f, 8'ha5);
        add_access(mdu_pkg::OP_READ, 5'h00, 8'h5a);
        add_access(mdu_pkg::OP_WRITE, 5'h1f, 8'hff);
        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_QL, 8'h00);

        // Random part: multiply and divide sequences with random operands, plus noise.
        next_drain = 1'b1;
        while (live_count < 850)
        begin
            if (live_count % 120 < 4)
            begin
                cur_gap_pct = $urandom_range(0, 2) * 25;
                cur_rx_pct = $urandom_range(0, 2) * 25;
            end
            if ($urandom_range(0, 24) == 0)
                next_drain = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    if ($urandom_range(0, 3) != 0)
                        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_MPYA, pick_byte());
                    add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_MPYB, pick_byte());
                    add_result_reads();
                end
                4, 5, 6, 7:
                begin
                    if ($urandom_range(0, 3) != 0)
                        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVL, pick_byte());
                    if ($urandom_range(0, 3) != 0)
                        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVH, pick_byte());
                    if ($urandom_range(0, 7) == 0)
                        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVB, 8'h00);
                    else
                        add_access(mdu_pkg::OP_WRITE, mdu_pkg::OFF_DIVB, pick_byte());
                    add_result_reads();
                end
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        add_access(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                   8'($urandom));
                end
            endcase
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (access_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("mul8_div16_register_unit: match");
        else
            $display("mul8_div16_register_unit: mismatch");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5ms;
        $display("mul8_div16_register_unit: mismatch");
        $finish;
    end

endmodule
